// ===== design/hsn_pkg.sv =====
package hsn_pkg;

    localparam int OVERTONES = 8;
    localparam int NHARM     = OVERTONES + 1;
    localparam int HW        = $clog2(NHARM);

    localparam int F0_W     = 20;
    localparam int SAMPLE_W = 16;
    localparam int HZ_W     = 40;
    localparam int AMP_W    = 15;
    localparam int SEED_W   = 32;
    localparam int PHASE_W  = 32;
    localparam int RAND_W   = 24;
    localparam int STEP_W   = 56;
    localparam int ADDR_W   = 6;
    localparam int DATA_W   = 64;

    localparam logic [HZ_W-1:0]   HZ_TO_STEP_RST   = 40'd11728124030;
    localparam logic [SEED_W-1:0] RNG_SEED_RST     = 32'd123456789;
    localparam logic [AMP_W-1:0]  TONE_AMP_RST     = 15'd3277;
    localparam logic [AMP_W-1:0]  NOISE_AMP_RST    = 15'd10;
    localparam logic [AMP_W-1:0]  UNVOICED_AMP_RST = 15'd1092;

    localparam logic [63:0] C1  = 64'd1686629713;
    localparam logic [63:0] C3  = 64'd693598668;
    localparam logic [63:0] C5  = 64'd85569306;
    localparam logic [63:0] C7  = 64'd5026995;
    localparam logic [63:0] C9  = 64'd172272;
    localparam logic [63:0] C11 = 64'd3864;

    typedef enum logic [2:0] {
        REG_HZ_TO_STEP   = 3'd0,
        REG_RNG_SEED     = 3'd1,
        REG_TONE_AMP     = 3'd2,
        REG_NOISE_AMP    = 3'd3,
        REG_UNVOICED_AMP = 3'd4
    } reg_idx_t;

    function automatic logic [SEED_W-1:0] xorshift(input logic [SEED_W-1:0] x);
        logic [SEED_W-1:0] a;
        logic [SEED_W-1:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

    function automatic logic [SAMPLE_W-1:0] quarter_sine(input logic [63:0] z);
        logic [63:0] z2;
        logic [63:0] acc;
        logic [63:0] y;
        logic [63:0] t;
        z2  = (z * z) >> 30;
        acc = C11;
        acc = C9 - ((acc * z2) >> 30);
        acc = C7 - ((acc * z2) >> 30);
        acc = C5 - ((acc * z2) >> 30);
        acc = C3 - ((acc * z2) >> 30);
        acc = C1 - ((acc * z2) >> 30);
        y   = (z * acc) >> 30;
        t   = (y * 64'd32767 + (64'd1 << 29)) >> 30;
        return t[SAMPLE_W-1:0];
    endfunction

endpackage

// ===== design/hsn_in_if.sv =====
interface hsn_in_if;
    import hsn_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [F0_W-1:0]  f0_hz;
    logic                    restart;

    modport source (output valid, output f0_hz, output restart, input ready);
    modport sink   (input valid, input f0_hz, input restart, output ready);
endinterface

// ===== design/hsn_out_if.sv =====
interface hsn_out_if;
    import hsn_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] harm_0;
    logic signed [SAMPLE_W-1:0] harm_1;
    logic signed [SAMPLE_W-1:0] harm_2;
    logic signed [SAMPLE_W-1:0] harm_3;
    logic signed [SAMPLE_W-1:0] harm_4;
    logic signed [SAMPLE_W-1:0] harm_5;
    logic signed [SAMPLE_W-1:0] harm_6;
    logic signed [SAMPLE_W-1:0] harm_7;
    logic signed [SAMPLE_W-1:0] harm_8;
    logic                       voiced;

    modport source (
        output valid, output harm_0, output harm_1, output harm_2, output harm_3,
        output harm_4, output harm_5, output harm_6, output harm_7, output harm_8,
        output voiced, input ready
    );
    modport sink (
        input valid, input harm_0, input harm_1, input harm_2, input harm_3,
        input harm_4, input harm_5, input harm_6, input harm_7, input harm_8,
        input voiced, output ready
    );
endinterface

// ===== design/harmonic_sine_noise_source.sv =====
// Harmonic sine-plus-noise source.
// Input channel tick: one beat per audio sample, carrying f0_hz (signed Q12.8 Hz)
// and restart. Output channel harm: one beat per input beat, nine Q15 samples
// (fundamental and eight overtones) and the voiced flag.
// Configuration: APB write/read of hz_to_step, rng_seed, tone_amp, noise_amp and
// unvoiced_amp at byte addresses 0, 8, 16, 24, 32; write only while idle.
// Flow: the harmonics go one per cycle through a shared pipe fed from the
// phase memory (one read and one write port). An accepted beat passes S_MUL,
// S_SUM, S_RUN and S_DRAIN before its result is offered; a restart beat also
// passes S_SEED between S_SUM and S_RUN to draw the overtone start phases.
// A new beat is taken once the previous one has left the pipe.
// Reset: registers take their documented defaults, the generator holds the
// default seed and all phases read as zero.
// Stall: a finished result waits in the output register; the next beat is
// still accepted and processed, and its result is held until harm takes the
// waiting one.
module harmonic_sine_noise_source #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    hsn_in_if.sink                      tick,
    hsn_out_if.source                   harm,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hsn_pkg::ADDR_W-1:0]  paddr,
    input  logic [hsn_pkg::DATA_W-1:0]  pwdata,
    output logic [hsn_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import hsn_pkg::*;

    localparam int QB    = SINE_TABLE_BITS - 2;
    localparam int Q     = 1 << QB;
    localparam int IDX_W = SINE_TABLE_BITS;
    localparam logic [SAMPLE_W-1:0] PEAK = quarter_sine(64'd1 << 30);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_SEED,
        S_RUN,
        S_DRAIN
    } state_t;

    logic [SAMPLE_W-1:0] qtab [Q];

    for (genvar g = 0; g < Q; g++)
    begin : g_qtab
        assign qtab[g] = quarter_sine(64'(g) << (30 - QB));
    end

    logic [HZ_W-1:0]   hz_to_step_reg;
    logic [SEED_W-1:0] rng_seed_reg;
    logic [AMP_W-1:0]  tone_amp_reg;
    logic [AMP_W-1:0]  noise_amp_reg;
    logic [AMP_W-1:0]  unvoiced_amp_reg;
    logic              cfg_we;
    logic [2:0]        cfg_idx;

    state_t            state_reg;
    logic [HW-1:0]     cnt_reg;
    logic [SEED_W-1:0] rand_reg;
    logic [SEED_W-1:0] rand_next;
    logic [RAND_W-1:0] draw;
    logic              voiced_reg;
    logic              restart_reg;
    logic [NHARM-1:0]  phase_valid_reg;

    logic [F0_W-2:0]   f0_reg;
    logic [38:0]       prod_lo_reg;
    logic [38:0]       prod_hi_reg;
    logic [STEP_W-1:0] base_sum;
    logic [STEP_W-1:0] base_reg;
    logic [STEP_W-1:0] step_reg;

    logic              p1_vld_reg;
    logic [HW-1:0]     p1_h_reg;
    logic [RAND_W-1:0] p1_u_reg;
    logic [PHASE_W-1:0] p1_step_reg;

    logic              p2_vld_reg;
    logic [HW-1:0]     p2_h_reg;
    logic              p2_neg_reg;
    logic              p2_peak_reg;
    logic [QB-1:0]     p2_midx_reg;
    logic signed [41:0] p2_nprod_reg;

    logic              p3_vld_reg;
    logic [HW-1:0]     p3_h_reg;
    logic signed [16:0] p3_s_reg;
    logic signed [17:0] p3_noise_reg;

    logic              p4_vld_reg;
    logic [HW-1:0]     p4_h_reg;
    logic signed [32:0] p4_sprod_reg;
    logic signed [17:0] p4_noise_reg;

    logic [SAMPLE_W-1:0] res_reg [NHARM];
    logic [SAMPLE_W-1:0] out_harm_reg [NHARM];
    logic                out_voiced_reg;
    logic                out_valid_reg;

    logic                 ram_we;
    logic [HW-1:0]        ram_waddr;
    logic [PHASE_W-1:0]   ram_wdata;
    logic [PHASE_W-1:0]   ram_rdata;

    logic [PHASE_W-1:0]   rd_phase;
    logic [PHASE_W-1:0]   phase_new;
    logic [IDX_W-1:0]     tidx;
    logic [1:0]           quad;
    logic [QB-1:0]        roff;
    logic [QB-1:0]        midx;
    logic signed [25:0]   nv;
    logic [AMP_W-1:0]     amp_sel;
    logic signed [41:0]   nprod;

    logic [SAMPLE_W-1:0]  tval;
    logic signed [16:0]   sval;
    logic signed [41:0]   nround;

    logic signed [32:0]   sprod;
    logic signed [32:0]   sround;
    logic signed [18:0]   mix;
    logic [SAMPLE_W-1:0]  sat;

    logic                 tick_accept;
    logic                 pipe_busy;
    logic                 load_out;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hz_to_step_reg   <= HZ_TO_STEP_RST;
            rng_seed_reg     <= RNG_SEED_RST;
            tone_amp_reg     <= TONE_AMP_RST;
            noise_amp_reg    <= NOISE_AMP_RST;
            unvoiced_amp_reg <= UNVOICED_AMP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_HZ_TO_STEP:   hz_to_step_reg   <= pwdata[HZ_W-1:0];
                REG_RNG_SEED:     rng_seed_reg     <= pwdata[SEED_W-1:0];
                REG_TONE_AMP:     tone_amp_reg     <= pwdata[AMP_W-1:0];
                REG_NOISE_AMP:    noise_amp_reg    <= pwdata[AMP_W-1:0];
                REG_UNVOICED_AMP: unvoiced_amp_reg <= pwdata[AMP_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_HZ_TO_STEP:   prdata = DATA_W'(hz_to_step_reg);
            REG_RNG_SEED:     prdata = DATA_W'(rng_seed_reg);
            REG_TONE_AMP:     prdata = DATA_W'(tone_amp_reg);
            REG_NOISE_AMP:    prdata = DATA_W'(noise_amp_reg);
            REG_UNVOICED_AMP: prdata = DATA_W'(unvoiced_amp_reg);
            default:          prdata = '0;
        endcase
    end

    // handshake and draw
    assign tick.ready  = (state_reg == S_IDLE);
    assign tick_accept = tick.valid && tick.ready;
    assign rand_next   = xorshift(rand_reg);
    assign draw        = rand_next[RAND_W-1:0];
    assign pipe_busy   = p1_vld_reg || p2_vld_reg || p3_vld_reg || p4_vld_reg;
    assign load_out    = (state_reg == S_DRAIN) && !pipe_busy
                         && (!out_valid_reg || harm.ready);

    // phase memory
    assign ram_we    = (state_reg == S_SEED) || (p1_vld_reg && voiced_reg);
    assign ram_waddr = (state_reg == S_SEED) ? cnt_reg : p1_h_reg;
    assign ram_wdata = (state_reg == S_SEED) ? {draw, 8'd0} : phase_new;

    hsn_ram #(
        .WIDTH (PHASE_W),
        .DEPTH (NHARM)
    ) u_phase_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    // stage 1: phase update, table address, noise product
    assign rd_phase  = phase_valid_reg[p1_h_reg] ? ram_rdata : '0;
    assign phase_new = rd_phase + p1_step_reg;
    assign tidx      = phase_new[PHASE_W-1 -: IDX_W];
    assign quad      = tidx[IDX_W-1 -: 2];
    assign roff      = tidx[QB-1:0];
    assign midx      = quad[0] ? (~roff + 1'b1) : roff;
    assign nv        = $signed({1'b0, p1_u_reg, 1'b0}) - 26'sh1000000;
    assign amp_sel   = voiced_reg ? noise_amp_reg : unvoiced_amp_reg;
    assign nprod     = nv * $signed({1'b0, amp_sel});

    // stage 2: table read, noise rounding
    assign tval   = p2_peak_reg ? PEAK : qtab[p2_midx_reg];
    assign sval   = p2_neg_reg ? -$signed({1'b0, tval}) : $signed({1'b0, tval});
    assign nround = p2_nprod_reg + 42'sd8388608;

    // stage 3: sine scaling
    assign sprod = p3_s_reg * $signed({1'b0, tone_amp_reg});

    // stage 4: rounding, mix, saturation
    assign sround = p4_sprod_reg + 33'sd16384;

    always_comb
    begin
        if (voiced_reg)
        begin
            mix = 19'($signed(sround[32:15])) + 19'(p4_noise_reg);
        end
        else
        begin
            mix = 19'(p4_noise_reg);
        end
        if (mix > 19'sd32767)
        begin
            sat = 16'h7FFF;
        end
        else if (mix < -19'sd32768)
        begin
            sat = 16'h8000;
        end
        else
        begin
            sat = mix[SAMPLE_W-1:0];
        end
    end

    assign base_sum = STEP_W'(prod_lo_reg) + {prod_hi_reg[STEP_W-21:0], 20'd0};

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            rand_reg        <= RNG_SEED_RST;
            voiced_reg      <= 1'b0;
            restart_reg     <= 1'b0;
            phase_valid_reg <= '0;
            p1_vld_reg      <= 1'b0;
            p2_vld_reg      <= 1'b0;
            p3_vld_reg      <= 1'b0;
            p4_vld_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= (state_reg == S_RUN);
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
            if (p1_vld_reg && voiced_reg)
            begin
                phase_valid_reg[p1_h_reg] <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (harm.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (tick_accept)
                    begin
                        voiced_reg  <= !tick.f0_hz[F0_W-1] && (tick.f0_hz != '0);
                        restart_reg <= tick.restart;
                        if (tick.restart)
                        begin
                            rand_reg           <= rng_seed_reg;
                            phase_valid_reg[0] <= 1'b0;
                        end
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    if (restart_reg)
                    begin
                        cnt_reg   <= HW'(1);
                        state_reg <= S_SEED;
                    end
                    else
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_SEED:
                begin
                    rand_reg                 <= rand_next;
                    phase_valid_reg[cnt_reg] <= 1'b1;
                    if (cnt_reg == HW'(OVERTONES))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_RUN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_RUN:
                begin
                    rand_reg <= rand_next;
                    if (cnt_reg == HW'(OVERTONES))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            f0_reg      <= tick.f0_hz[F0_W-2:0];
            prod_lo_reg <= tick.f0_hz[F0_W-2:0] * hz_to_step_reg[19:0];
        end
        if (state_reg == S_MUL)
        begin
            prod_hi_reg <= f0_reg * hz_to_step_reg[HZ_W-1:20];
        end
        if (state_reg == S_SUM)
        begin
            base_reg <= base_sum;
            step_reg <= base_sum;
        end
        if (state_reg == S_RUN)
        begin
            step_reg <= step_reg + base_reg;
        end

        p1_h_reg    <= cnt_reg;
        p1_u_reg    <= draw;
        p1_step_reg <= step_reg[STEP_W-1 -: PHASE_W];

        p2_h_reg     <= p1_h_reg;
        p2_neg_reg   <= quad[1];
        p2_peak_reg  <= quad[0] && (roff == '0);
        p2_midx_reg  <= midx;
        p2_nprod_reg <= nprod;

        p3_h_reg     <= p2_h_reg;
        p3_s_reg     <= sval;
        p3_noise_reg <= nround[41:24];

        p4_h_reg     <= p3_h_reg;
        p4_sprod_reg <= sprod;
        p4_noise_reg <= p3_noise_reg;

        if (p4_vld_reg)
        begin
            res_reg[p4_h_reg] <= sat;
        end
        if (load_out)
        begin
            out_harm_reg   <= res_reg;
            out_voiced_reg <= voiced_reg;
        end
    end

    assign harm.valid  = out_valid_reg;
    assign harm.harm_0 = out_harm_reg[0];
    assign harm.harm_1 = out_harm_reg[1];
    assign harm.harm_2 = out_harm_reg[2];
    assign harm.harm_3 = out_harm_reg[3];
    assign harm.harm_4 = out_harm_reg[4];
    assign harm.harm_5 = out_harm_reg[5];
    assign harm.harm_6 = out_harm_reg[6];
    assign harm.harm_7 = out_harm_reg[7];
    assign harm.harm_8 = out_harm_reg[8];
    assign harm.voiced = out_voiced_reg;

endmodule

// ===== design/hsn_ram.sv =====
module hsn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 9
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import hsn_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic signed [F0_W-1:0] F0_MAX = 20'sh7FFFF;
    localparam logic signed [F0_W-1:0] F0_MIN = 20'sh80000;

    typedef struct packed {
        logic [NHARM-1:0][SAMPLE_W-1:0] harm;
        logic                           voiced;
    } harm_beat_t;

    class harmonic_scoreboard;
        localparam int TABLE_BITS = 10;
        localparam int QBITS      = TABLE_BITS - 2;

        logic [HZ_W-1:0]    hz_step;
        logic [SEED_W-1:0]  seed;
        logic [AMP_W-1:0]   tone_amp;
        logic [AMP_W-1:0]   noise_amp;
        logic [AMP_W-1:0]   unvoiced_amp;
        logic [SEED_W-1:0]  rng;
        logic [PHASE_W-1:0] phase [NHARM];
        harm_beat_t         due_samples [$];
        int                 mismatches;

        function new();
            hz_step      = HZ_TO_STEP_RST;
            seed         = RNG_SEED_RST;
            tone_amp     = TONE_AMP_RST;
            noise_amp    = NOISE_AMP_RST;
            unvoiced_amp = UNVOICED_AMP_RST;
            rng          = RNG_SEED_RST;
            foreach (phase[h])
                phase[h] = '0;
            mismatches = 0;
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_HZ_TO_STEP:   hz_step      = value[HZ_W-1:0];
                REG_RNG_SEED:     seed         = value[SEED_W-1:0];
                REG_TONE_AMP:     tone_amp     = value[AMP_W-1:0];
                REG_NOISE_AMP:    noise_amp    = value[AMP_W-1:0];
                REG_UNVOICED_AMP: unvoiced_amp = value[AMP_W-1:0];
                default:          ;
            endcase
        endfunction

        function logic [DATA_W-1:0] reg_value(reg_idx_t idx);
            case (idx)
                REG_HZ_TO_STEP:   return DATA_W'(hz_step);
                REG_RNG_SEED:     return DATA_W'(seed);
                REG_TONE_AMP:     return DATA_W'(tone_amp);
                REG_NOISE_AMP:    return DATA_W'(noise_amp);
                REG_UNVOICED_AMP: return DATA_W'(unvoiced_amp);
                default:          return '0;
            endcase
        endfunction

        function logic [RAND_W-1:0] next_draw();
            logic [SEED_W-1:0] x;
            x   = rng;
            x   = x ^ (x << 13);
            x   = x ^ (x >> 17);
            x   = x ^ (x << 5);
            rng = x;
            return x[RAND_W-1:0];
        endfunction

        // uniform value in [-1, 1) scaled by amp, rounded half up
        function longint noise_q15(logic [AMP_W-1:0] amp);
            longint v;
            longint p;
            v = 2 * longint'(next_draw()) - (longint'(1) << 24);
            p = v * longint'(amp);
            return (p + (longint'(1) << 23)) >>> 24;
        endfunction

        function longint sine_entry(logic [TABLE_BITS-1:0] idx);
            logic [1:0]  quad;
            logic [63:0] m;
            logic [63:0] z;
            logic [63:0] z2;
            logic [63:0] acc;
            logic [63:0] y;
            longint      s;
            quad = idx[TABLE_BITS-1 -: 2];
            m    = 64'(idx[QBITS-1:0]);
            if (quad[0])
                m = (64'd1 << QBITS) - m;
            z   = m << (30 - QBITS);
            z2  = (z * z) >> 30;
            acc = C11;
            acc = C9 - ((acc * z2) >> 30);
            acc = C7 - ((acc * z2) >> 30);
            acc = C5 - ((acc * z2) >> 30);
            acc = C3 - ((acc * z2) >> 30);
            acc = C1 - ((acc * z2) >> 30);
            y   = (z * acc) >> 30;
            s   = longint'((y * 64'd32767 + (64'd1 << 29)) >> 30);
            return quad[1] ? -s : s;
        endfunction

        function logic [SAMPLE_W-1:0] clip16(longint v);
            if (v > 32767)
                return 16'h7FFF;
            if (v < -32768)
                return 16'h8000;
            return SAMPLE_W'(v);
        endfunction

        function void note_tick(logic signed [F0_W-1:0] f0, logic restart);
            harm_beat_t  want;
            logic [63:0] f0_mag;
            logic [63:0] prod;
            longint      sample;
            logic        voiced;
            int          h;
            voiced = (f0 > 0);
            if (restart)
            begin
                rng      = seed;
                phase[0] = '0;
                for (h = 1; h < NHARM; h++)
                    phase[h] = {next_draw(), 8'd0};
            end
            f0_mag = 64'(f0[F0_W-2:0]);
            for (h = 0; h < NHARM; h++)
            begin
                if (voiced)
                begin
                    prod     = 64'(h + 1) * f0_mag * 64'(hz_step);
                    phase[h] = phase[h] + prod[55:24];
                    sample   = sine_entry(phase[h][PHASE_W-1 -: TABLE_BITS]) * longint'(tone_amp);
                    sample   = ((sample + longint'(1 << 14)) >>> 15) + noise_q15(noise_amp);
                end
                else
                begin
                    sample = noise_q15(unvoiced_amp);
                end
                want.harm[h] = clip16(sample);
            end
            want.voiced = voiced;
            due_samples.push_back(want);
        endfunction

        task check_harm(harm_beat_t got);
            harm_beat_t want;
            int         h;
            if (due_samples.size() == 0)
            begin
                report("harm beat with no sample set pending");
                return;
            end
            want = due_samples.pop_front();
            for (h = 0; h < NHARM; h++)
                if (got.harm[h] !== want.harm[h])
                    report($sformatf("harm_%0d got %0d want %0d", h,
                                     $signed(got.harm[h]), $signed(want.harm[h])));
            if (got.voiced !== want.voiced)
                report($sformatf("voiced got %0b want %0b", got.voiced, want.voiced));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                steady;
    int unsigned         cycles;

    harmonic_scoreboard  sb = new();

    hsn_in_if  tick_bus ();
    hsn_out_if harm_bus ();

    harmonic_sine_noise_source i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick_bus),
        .harm    (harm_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        harm_bus.ready <= steady || ($urandom_range(99) >= 34);
    end

    always @(posedge clk)
    begin
        harm_beat_t got;
        if (rst_n && harm_bus.valid && harm_bus.ready)
        begin
            got.harm[0] = harm_bus.harm_0;
            got.harm[1] = harm_bus.harm_1;
            got.harm[2] = harm_bus.harm_2;
            got.harm[3] = harm_bus.harm_3;
            got.harm[4] = harm_bus.harm_4;
            got.harm[5] = harm_bus.harm_5;
            got.harm[6] = harm_bus.harm_6;
            got.harm[7] = harm_bus.harm_7;
            got.harm[8] = harm_bus.harm_8;
            got.voiced  = harm_bus.voiced;
            sb.check_harm(got);
        end
        if (rst_n && tick_bus.valid && tick_bus.ready)
            sb.note_tick(tick_bus.f0_hz, tick_bus.restart);
    end

    task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_regs();
        reg_idx_t          idx;
        logic [DATA_W-1:0] got;
        idx = idx.first();
        do
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= ADDR_W'({idx, 3'b000});
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            got = prdata;
            if (got !== sb.reg_value(idx))
                sb.report($sformatf("%s read 0x%0h want 0x%0h", idx.name(), got,
                                    sb.reg_value(idx)));
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge clk);
            idx = idx.next();
        end
        while (idx != idx.first());
    endtask

    task automatic load_config(logic [HZ_W-1:0] hz, logic [SEED_W-1:0] seed,
                               logic [AMP_W-1:0] sine, logic [AMP_W-1:0] noise,
                               logic [AMP_W-1:0] unvoiced);
        reg_write(REG_HZ_TO_STEP, DATA_W'(hz));
        reg_write(REG_RNG_SEED, DATA_W'(seed));
        reg_write(REG_TONE_AMP, DATA_W'(sine));
        reg_write(REG_NOISE_AMP, DATA_W'(noise));
        reg_write(REG_UNVOICED_AMP, DATA_W'(unvoiced));
        check_regs();
    endtask

    task automatic send_tick(logic signed [F0_W-1:0] f0, logic restart);
        while (!steady && $urandom_range(99) < 34)
        begin
            tick_bus.valid <= 1'b0;
            @(posedge clk);
        end
        tick_bus.valid   <= 1'b1;
        tick_bus.f0_hz   <= f0;
        tick_bus.restart <= restart;
        do
            @(posedge clk);
        while (!tick_bus.ready);
    endtask

    task automatic drain_stream();
        tick_bus.valid <= 1'b0;
        while (sb.due_samples.size() != 0)
            @(posedge clk);
    endtask

    // mostly voiced runs opened by a restart, with some stray ticks between
    task automatic run_phase(int n_ticks);
        int                     sent;
        int                     run_len;
        int                     i;
        logic signed [F0_W-1:0] pitch;
        sent = 0;
        while (sent < n_ticks)
        begin
            if ($urandom_range(9) < 7)
            begin
                pitch = F0_W'($urandom_range(128000, 12800));
                send_tick(pitch, 1'b1);
                run_len = $urandom_range(12, 3);
                for (i = 0; i < run_len; i++)
                begin
                    if ($urandom_range(5) == 0)
                        send_tick(-F0_W'($urandom_range(3)), 1'b0);
                    else
                        send_tick(pitch + F0_W'($urandom_range(64)) - F0_W'(32), 1'b0);
                end
                sent += run_len + 1;
            end
            else
            begin
                send_tick(F0_W'($urandom), 1'($urandom));
                sent++;
            end
        end
        drain_stream();
    endtask

    initial
    begin
        int p;
        rst_n            = 1'b0;
        steady           = 1'b0;
        cycles           = 0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        tick_bus.valid   = 1'b0;
        tick_bus.f0_hz   = '0;
        tick_bus.restart = 1'b0;
        harm_bus.ready   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_regs();
        send_tick(F0_W'(25600), 1'b0);
        send_tick(F0_W'(25600), 1'b1);
        send_tick(F0_W'(25600), 1'b0);
        send_tick(F0_W'(25700), 1'b0);
        send_tick('0, 1'b0);
        send_tick(-F0_W'(1), 1'b0);
        send_tick(F0_MIN, 1'b0);
        send_tick(F0_W'(1), 1'b0);
        send_tick(F0_MAX, 1'b0);
        send_tick(F0_MAX, 1'b1);
        send_tick('0, 1'b1);
        send_tick(F0_MIN, 1'b1);
        send_tick(20'sh55555, 1'b0);
        send_tick(20'sh2AAAA, 1'b0);
        send_tick(F0_W'(128000), 1'b0);
        drain_stream();

        // saturating amplitudes, wrapping steps and a stuck generator
        load_config({HZ_W{1'b1}}, '0, 15'h7FFF, 15'h7FFF, 15'h7FFF);
        run_phase(64);
        load_config('0, {SEED_W{1'b1}}, '0, '0, '0);
        run_phase(64);

        steady = 1'b1;
        load_config(HZ_TO_STEP_RST, RNG_SEED_RST, TONE_AMP_RST, NOISE_AMP_RST,
                    UNVOICED_AMP_RST);
        run_phase(64);
        steady = 1'b0;

        for (p = 0; p < 3; p++)
        begin
            load_config(($urandom_range(1) == 0) ? {8'($urandom), 32'($urandom)}
                                                 : (40'd1 << $urandom_range(36, 30))
                                                   + 40'($urandom),
                        $urandom, 15'($urandom), 15'($urandom), 15'($urandom));
            run_phase(64);
        end

        repeat (40) @(posedge clk);
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/hsn_pkg.sv
design/hsn_in_if.sv
design/hsn_out_if.sv
design/hsn_ram.sv
design/harmonic_sine_noise_source.sv
dv/tb_top.sv
